@@ hdl/sorted_array_binary_search_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the binary search core
// Concurrent check wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_BINARY_SEARCH_CORE_MACROS_SVH
`define SORTED_ARRAY_BINARY_SEARCH_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SABS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sabs same-cycle check failed");

// next-cycle implication
`define SABS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sabs next-cycle check failed");

`else

`define SABS_ASSERT_SAME(label, clk, rst, ante, cons)
`define SABS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hdl/sabs_pkg.sv @@
// ----------------------------------------------------------------------------
// sabs_pkg
// Shared constants, state encoding and result record for the search core.
// ----------------------------------------------------------------------------
`default_nettype none

package sabs_pkg;

   localparam int STORE_DEPTH_DEFAULT = 1024;
   localparam int VALUE_W             = 32;
   localparam int INDEX_W             = 10;
   localparam int HIGH_W              = 11;

   localparam logic MODE_WRITE  = 1'b0;
   localparam logic MODE_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE,
      ST_RESULT
   } state_type;

   // finished search handed from engine to output register
   typedef struct packed {
      logic               done;
      logic               found;
      logic [INDEX_W-1:0] position;
   } result_type;

endpackage

`default_nettype wire

@@ hdl/sabs_ram.sv @@
// ----------------------------------------------------------------------------
// sabs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sabs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ hdl/sabs_engine.sv @@
// ----------------------------------------------------------------------------
// sabs_engine
// Write path and probe sequencer: one memory read per probe, then compare.
// ----------------------------------------------------------------------------
`default_nettype none

module sabs_engine #(
   parameter int STORE_DEPTH = sabs_pkg::STORE_DEPTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 accept,
   input  wire logic                                 mode,
   input  wire logic        [sabs_pkg::INDEX_W-1:0]  write_index,
   input  wire logic        [sabs_pkg::INDEX_W-1:0]  search_low,
   input  wire logic signed [sabs_pkg::HIGH_W-1:0]   search_high,
   input  wire logic signed [sabs_pkg::VALUE_W-1:0]  value,
   input  wire logic                                 out_free,
   output logic                                      busy,
   output sabs_pkg::result_type                      result,
   output logic                                      ram_wr_en,
   output logic             [$clog2(STORE_DEPTH)-1:0] ram_wr_addr,
   output logic             [sabs_pkg::VALUE_W-1:0]  ram_wr_data,
   output logic                                      ram_rd_en,
   output logic             [$clog2(STORE_DEPTH)-1:0] ram_rd_addr,
   input  wire logic        [sabs_pkg::VALUE_W-1:0]  ram_rd_data
);

   localparam int AW = $clog2(STORE_DEPTH);
   // range bounds: index bits plus room for -1 and mid+1
   localparam int IW = ((AW > sabs_pkg::INDEX_W) ? AW : sabs_pkg::INDEX_W) + 2;
   localparam logic signed [IW-1:0] LAST_INDEX = IW'(STORE_DEPTH - 1);
   localparam logic signed [IW-1:0] ONE        = IW'(1);

   sabs_pkg::state_type state_ff, state_in;

   logic signed [IW-1:0]                lo_ff, lo_in;
   logic signed [IW-1:0]                hi_ff, hi_in;
   logic signed [IW-1:0]                mid_ff, mid_in;
   logic signed [sabs_pkg::VALUE_W-1:0] key_ff, key_in;
   logic                                hit_ff, hit_in;

   logic signed [IW-1:0]                low_ext;
   logic signed [IW-1:0]                high_ext;
   logic signed [IW-1:0]                high_sat;
   logic signed [IW-1:0]                widx_ext;
   logic signed [IW-1:0]                mid;
   logic signed [sabs_pkg::VALUE_W-1:0] elem;

   assign low_ext  = {{(IW - sabs_pkg::INDEX_W){1'b0}}, search_low};
   assign high_ext = {{(IW - sabs_pkg::HIGH_W){search_high[sabs_pkg::HIGH_W-1]}}, search_high};
   assign high_sat = (high_ext > LAST_INDEX) ? LAST_INDEX : high_ext;
   assign widx_ext = {{(IW - sabs_pkg::INDEX_W){1'b0}}, write_index};
   // lo <= hi whenever this is used, so the span is non-negative
   assign mid      = lo_ff + ((hi_ff - lo_ff) >>> 1);
   assign elem     = $signed(ram_rd_data);

   assign ram_wr_addr = widx_ext[AW-1:0];
   assign ram_wr_data = value;
   assign ram_rd_addr = mid[AW-1:0];
   assign busy        = (state_ff != sabs_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sabs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      key_ff <= key_in;
      hit_ff <= hit_in;
   end

   always_comb begin
      state_in  = state_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      mid_in    = mid_ff;
      key_in    = key_ff;
      hit_in    = hit_ff;
      ram_wr_en = 1'b0;
      ram_rd_en = 1'b0;
      result    = '0;
      unique case (state_ff)
         sabs_pkg::ST_IDLE: begin
            if (accept) begin
               if (mode == sabs_pkg::MODE_SEARCH) begin
                  lo_in    = low_ext;
                  hi_in    = high_sat;
                  key_in   = value;
                  hit_in   = 1'b0;
                  state_in = sabs_pkg::ST_PROBE;
               end else begin
                  // out-of-range writes are dropped
                  ram_wr_en = (widx_ext <= LAST_INDEX);
               end
            end
         end
         sabs_pkg::ST_PROBE: begin
            if (lo_ff > hi_ff) begin
               state_in = sabs_pkg::ST_RESULT;
            end else begin
               ram_rd_en = 1'b1;
               mid_in    = mid;
               state_in  = sabs_pkg::ST_COMPARE;
            end
         end
         sabs_pkg::ST_COMPARE: begin
            if (key_ff == elem) begin
               hit_in   = 1'b1;
               state_in = sabs_pkg::ST_RESULT;
            end else begin
               if (key_ff > elem) begin
                  lo_in = mid_ff + ONE;
               end else begin
                  hi_in = mid_ff - ONE;
               end
               state_in = sabs_pkg::ST_PROBE;
            end
         end
         sabs_pkg::ST_RESULT: begin
            if (out_free) begin
               result.done     = 1'b1;
               result.found    = hit_ff;
               result.position = hit_ff ? mid_ff[sabs_pkg::INDEX_W-1:0] : '0;
               state_in        = sabs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sabs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ hdl/sorted_array_binary_search_core.sv @@
// Sequence: a write lands in memory at its accept edge; a search repeats a probe
//   (read, then compare) until a compare hits or an empty-range check ends it,
//   then loads the result register once the result slot is free.
// Throughput: one transaction at a time; writes back to back, the request after
//   a search is taken at the edge after its result loads.
// Synchronous active-high reset clears control only; memory is undefined.
// ----------------------------------------------------------------------------
// sorted_array_binary_search_core
// Element store with binary search over an inclusive, ascending index range.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_array_binary_search_core_macros.svh"

module sorted_array_binary_search_core #(
   parameter int STORE_DEPTH = sabs_pkg::STORE_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_mode,
   input  wire logic        [sabs_pkg::INDEX_W-1:0] req_write_index,
   input  wire logic        [sabs_pkg::INDEX_W-1:0] req_search_low,
   input  wire logic signed [sabs_pkg::HIGH_W-1:0]  req_search_high,
   input  wire logic signed [sabs_pkg::VALUE_W-1:0] req_value,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_found,
   output logic             [sabs_pkg::INDEX_W-1:0] rsp_position
);

   localparam int AW = $clog2(STORE_DEPTH);

   logic                          req_accept;
   logic                          engine_busy;
   logic                          out_free;
   sabs_pkg::result_type          result;

   logic                          ram_wr_en;
   logic [AW-1:0]                 ram_wr_addr;
   logic [sabs_pkg::VALUE_W-1:0]  ram_wr_data;
   logic                          ram_rd_en;
   logic [AW-1:0]                 ram_rd_addr;
   logic [sabs_pkg::VALUE_W-1:0]  ram_rd_data;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [sabs_pkg::INDEX_W-1:0]  rsp_position_ff, rsp_position_in;

   // qualifiers for the checks at the end
   logic                          write_accept;
   logic                          search_accept;
   logic                          rsp_miss;

   // The engine is the only memory user and takes one transaction at a time,
   // so a read can never race a write to the same entry: stalling the request
   // channel while a search runs is the interlock.
   assign req_stall  = engine_busy;
   assign req_accept = req_valid && !req_stall;

   // result slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   sabs_engine #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .mode        (req_mode),
      .write_index (req_write_index),
      .search_low  (req_search_low),
      .search_high (req_search_high),
      .value       (req_value),
      .out_free    (out_free),
      .busy        (engine_busy),
      .result      (result),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   sabs_ram #(
      .WIDTH (sabs_pkg::VALUE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Load on a finished search, otherwise drop once the consumer takes it.
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      if (result.done) begin
         rsp_valid_in    = 1'b1;
         rsp_found_in    = result.found;
         rsp_position_in = result.position;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   assign write_accept  = req_accept && (req_mode == sabs_pkg::MODE_WRITE);
   assign search_accept = req_accept && (req_mode == sabs_pkg::MODE_SEARCH);
   assign rsp_miss      = rsp_valid_ff && !rsp_found_ff;

   // a finished search must never overwrite a response still being held
   `SABS_ASSERT_SAME(a_no_overwrite, clock, reset, result.done, out_free)
   // a miss always reports position zero
   `SABS_ASSERT_SAME(a_miss_pos_zero, clock, reset, rsp_miss, rsp_position_ff == '0)
   // a write completes in its accept cycle and leaves the engine free
   `SABS_ASSERT_NEXT(a_write_one_cycle, clock, reset, write_accept, !req_stall)
   // a search holds off further requests while it runs
   `SABS_ASSERT_NEXT(a_search_busy, clock, reset, search_accept, req_stall)

endmodule

`default_nettype wire

@@ verif/sorted_array_binary_search_core_checker.sv @@
// ----------------------------------------------------------------------------
// sorted_array_binary_search_core_checker
// Watches both channels, keeps its own element store and predicts every
// search transaction; accepted responses are compared in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_array_binary_search_core_checker #(
   parameter int STORE_DEPTH = sabs_pkg::STORE_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic                                req_mode,
   input  wire logic        [sabs_pkg::INDEX_W-1:0] req_write_index,
   input  wire logic        [sabs_pkg::INDEX_W-1:0] req_search_low,
   input  wire logic signed [sabs_pkg::HIGH_W-1:0]  req_search_high,
   input  wire logic signed [sabs_pkg::VALUE_W-1:0] req_value,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire logic                                rsp_found,
   input  wire logic        [sabs_pkg::INDEX_W-1:0] rsp_position,
   output int                                       mismatch_count,
   output int                                       pending
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int   INDEX_W    = sabs_pkg::INDEX_W;
   localparam int   VALUE_W    = sabs_pkg::VALUE_W;
   localparam logic MODE_WRITE = sabs_pkg::MODE_WRITE;

   typedef struct packed {
      logic               found;
      logic [INDEX_W-1:0] position;
   } lookup_type;

   logic signed [VALUE_W-1:0] element_copy [STORE_DEPTH];
   lookup_type                expected_lookups [$];

   // binary search over the local copy; empty range gives not found at 0
   function automatic lookup_type predict_lookup(input int lo, input int hi,
                                                 input logic signed [VALUE_W-1:0] key);
      lookup_type                res;
      int                        mid;
      logic signed [VALUE_W-1:0] elem;
      res = '0;
      if (hi > STORE_DEPTH - 1) hi = STORE_DEPTH - 1;
      while (lo <= hi && !res.found) begin
         mid  = lo + (hi - lo) / 2;
         elem = element_copy[mid];
         if (key > elem) begin
            lo = mid + 1;
         end else if (key < elem) begin
            hi = mid - 1;
         end else begin
            res.found    = 1'b1;
            res.position = mid[INDEX_W-1:0];
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      lookup_type want;
      int         hi_signed;
      if (!reset) begin
         // response first: it can never belong to a request taken at this edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_lookups.size() == 0) begin
               $error("unexpected response: found %0d position %0d",
                      rsp_found, rsp_position);
               mismatch_count++;
            end else begin
               want = expected_lookups.pop_front();
               if (rsp_found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_found);
                  mismatch_count++;
               end
               if (rsp_position !== want.position) begin
                  $error("position: expected %0d, actual %0d",
                         want.position, rsp_position);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (req_mode == MODE_WRITE) begin
               if (int'(req_write_index) < STORE_DEPTH)
                  element_copy[req_write_index] = req_value;
            end else begin
               hi_signed = req_search_high;
               expected_lookups.push_back(
                  predict_lookup(int'(req_search_low), hi_signed, req_value));
            end
         end
      end
      pending = expected_lookups.size();
   end

endmodule

`default_nettype wire

@@ verif/sorted_array_binary_search_core_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_array_binary_search_core_tb
// Drives writes and searches into the core with random idle and stall, fills
// the whole store ascending and searches it; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_array_binary_search_core_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int   INDEX_W     = sabs_pkg::INDEX_W;
   localparam int   HIGH_W      = sabs_pkg::HIGH_W;
   localparam int   VALUE_W     = sabs_pkg::VALUE_W;
   localparam logic MODE_WRITE  = sabs_pkg::MODE_WRITE;
   localparam logic MODE_SEARCH = sabs_pkg::MODE_SEARCH;

   localparam int DEPTH        = sabs_pkg::STORE_DEPTH_DEFAULT;
   localparam int MIXED_ITEMS  = 800;       // transactions after the full fill
   localparam int HOLD_CYCLES  = 400;       // long response hold-off
   localparam int DRAIN_CYCLES = 40;        // above worst search latency
   localparam int CYCLE_LIMIT  = 1_000_000;

   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_mode;
   logic        [INDEX_W-1:0] req_write_index;
   logic        [INDEX_W-1:0] req_search_low;
   logic signed [HIGH_W-1:0]  req_search_high;
   logic signed [VALUE_W-1:0] req_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic                      rsp_found;
   logic        [INDEX_W-1:0] rsp_position;

   int mismatch_count;
   int pending;

   // stimulus-side picture of the store, only used to pick keys and bounds
   logic signed [VALUE_W-1:0] shadow_mem [DEPTH];

   // no-idle stretches, one counter per side
   int send_quiet;
   int recv_quiet;

   sorted_array_binary_search_core #(
      .STORE_DEPTH (DEPTH)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_write_index (req_write_index),
      .req_search_low  (req_search_low),
      .req_search_high (req_search_high),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position)
   );

   sorted_array_binary_search_core_checker #(
      .STORE_DEPTH (DEPTH)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_write_index (req_write_index),
      .req_search_low  (req_search_low),
      .req_search_high (req_search_high),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .mismatch_count  (mismatch_count),
      .pending         (pending)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // reset asserted from time zero, released at a falling edge
   initial begin
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // idle count per transaction: 0..12, now and then a run of zeros
   function automatic int draw_gap(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         quiet_left = $urandom_range(20, 60);
         return 0;
      end
      return $urandom_range(0, 12);
   endfunction

   // one request transaction; entered and left at a falling edge
   task automatic push_request(input logic mode, input logic [INDEX_W-1:0] widx,
                               input logic [INDEX_W-1:0] lo,
                               input logic signed [HIGH_W-1:0] hi,
                               input logic signed [VALUE_W-1:0] val);
      int gap;
      gap = draw_gap(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode        <= mode;
      req_write_index <= widx;
      req_search_low  <= lo;
      req_search_high <= hi;
      req_value       <= val;
      req_valid       <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      if (mode == MODE_WRITE) shadow_mem[widx] = val;
   endtask

   // search fields are don't-care on a write, so they get noise
   task automatic push_write(input int idx, input logic signed [VALUE_W-1:0] val);
      logic [INDEX_W-1:0]       lo_noise;
      logic signed [HIGH_W-1:0] hi_noise;
      lo_noise = INDEX_W'($urandom_range(0, DEPTH - 1));
      hi_noise = HIGH_W'($urandom_range(0, 2047));
      push_request(MODE_WRITE, idx[INDEX_W-1:0], lo_noise, hi_noise, val);
   endtask

   task automatic push_search(input int lo, input int hi,
                              input logic signed [VALUE_W-1:0] key);
      logic [INDEX_W-1:0] widx_noise;
      widx_noise = INDEX_W'($urandom_range(0, DEPTH - 1));
      push_request(MODE_SEARCH, widx_noise, lo[INDEX_W-1:0], hi[HIGH_W-1:0], key);
   endtask

   // ---------------------------------------------------------------------------
   // response side: random stall per transaction, two long hold-offs so the
   // core backs up and stalls its request channel while writes keep coming
   // ---------------------------------------------------------------------------
   initial begin : response_sink
      int taken;
      int hold;
      rsp_stall = 1'b0;
      taken     = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         hold = draw_gap(recv_quiet);
         if (taken == 40 || taken == 350) hold += HOLD_CYCLES;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         @(negedge clock);
      end
   end

   // watchdog: cycle count far above the slowest legal run
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------------
   initial begin : stimulus
      logic signed [VALUE_W-1:0] fill_val [DEPTH];
      int                        fill_order [DEPTH];
      logic signed [VALUE_W-1:0] key;
      longint                    acc;
      longint                    lo_b;
      longint                    hi_b;
      longint unsigned           span;
      int                        items;
      int                        pick;
      int                        lo;
      int                        hi;
      int                        idx;
      int                        run;
      int                        j;
      int                        tmp;

      // everything known from time zero
      req_valid       = 1'b0;
      req_mode        = MODE_WRITE;
      req_write_index = '0;
      req_search_low  = '0;
      req_search_high = '0;
      req_value       = '0;

      @(negedge clock);
      while (reset) @(negedge clock);

      // --- directed: small sorted block with a duplicate and both extremes ---
      push_write(0, VAL_MIN);
      push_write(1, -1000);
      push_write(2, -1000);
      push_write(3, 0);
      push_write(4, 5);
      push_write(5, 77);
      push_write(6, VAL_MAX);
      push_write(1022, 41);
      push_write(1023, 42);

      push_search(0, 6, VAL_MIN);     // first element
      push_search(0, 6, VAL_MAX);     // last element
      push_search(0, 6, 5);
      push_search(0, 6, -1000);       // duplicate run, midpoint decides
      push_search(0, 6, 3);           // falls between two elements
      push_search(1, 6, VAL_MIN);     // below the range
      push_search(0, 5, VAL_MAX);     // above the range
      push_search(3, 3, 0);           // single element hit
      push_search(3, 3, 1);           // single element miss
      push_search(4, 2, 5);           // low above high
      push_search(0, -1, 0);          // high of minus one
      push_search(0, -1024, 0);       // most negative high
      push_search(1023, 1023, 42);    // top of store
      push_search(1022, 1023, 41);
      push_search(1022, 1023, 43);
      push_search(1023, -1, 42);      // low at max, empty anyway

      // --- full ascending fill, random steps with some duplicates, shuffled ---
      acc = -64'sd2147483648;
      for (int i = 0; i < DEPTH; i++) begin
         fill_val[i]   = acc[VALUE_W-1:0];
         fill_order[i] = i;
         if ($urandom_range(0, 7) != 0) acc += $urandom_range(1, 8_000_000);
         if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      end
      fill_val[DEPTH-1] = VAL_MAX;
      for (int i = DEPTH - 1; i > 0; i--) begin
         j             = $urandom_range(0, i);
         tmp           = fill_order[i];
         fill_order[i] = fill_order[j];
         fill_order[j] = tmp;
      end
      for (int i = 0; i < DEPTH; i++) push_write(fill_order[i], fill_val[fill_order[i]]);

      // --- mixed: mostly searches of the sorted store, writes that keep it
      //     sorted, duplicate runs, and a little unsorted noise ---
      items = 0;
      while (items < MIXED_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 62) begin
            tmp = $urandom_range(0, 99);
            if (tmp < 55) begin
               lo = $urandom_range(0, DEPTH - 1);
               hi = $urandom_range(lo, DEPTH - 1);
            end else if (tmp < 72) begin
               lo = 0;
               hi = DEPTH - 1;
            end else if (tmp < 88) begin
               lo = $urandom_range(0, DEPTH - 1);
               hi = lo + $urandom_range(0, 7);
               if (hi > DEPTH - 1) hi = DEPTH - 1;
            end else if (tmp < 94) begin
               lo = $urandom_range(0, DEPTH - 1);
               hi = -$urandom_range(1, 1024);
            end else begin
               lo = $urandom_range(1, DEPTH - 1);
               hi = $urandom_range(0, lo - 1);
            end
            tmp = $urandom_range(0, 99);
            if (hi >= lo && tmp < 50) begin
               key = shadow_mem[$urandom_range(lo, hi)];
            end else if (hi >= lo && tmp < 70) begin
               key = shadow_mem[$urandom_range(lo, hi)] + ($urandom_range(0, 1) ? 1 : -1);
            end else if (tmp < 90) begin
               key = $urandom;
            end else begin
               key = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
            end
            push_search(lo, hi, key);
            items++;
         end else if (pick < 80) begin
            // value between the neighbors keeps the order
            idx  = $urandom_range(0, DEPTH - 1);
            lo_b = (idx > 0) ? longint'(shadow_mem[idx-1]) : longint'(VAL_MIN);
            hi_b = (idx < DEPTH - 1) ? longint'(shadow_mem[idx+1]) : longint'(VAL_MAX);
            if (hi_b >= lo_b) begin
               span = longint'(hi_b - lo_b);
               acc  = lo_b + longint'({$urandom, $urandom} % (span + 1));
            end else begin
               acc = lo_b;
            end
            push_write(idx, acc[VALUE_W-1:0]);
            items++;
         end else if (pick < 93) begin
            // run of copies of its first element: still ascending
            idx = $urandom_range(0, DEPTH - 2);
            run = $urandom_range(2, 8);
            key = shadow_mem[idx];
            for (int k = idx + 1; k < idx + run && k < DEPTH; k++) begin
               push_write(k, key);
               items++;
            end
         end else begin
            key = $urandom;
            push_write($urandom_range(0, DEPTH - 1), key);
            items++;
         end
      end

      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
